>>> rtl/core/mer_pkg.sv
// Shared types and constants for the midpoint ellipse rasterizer.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package mer_pkg;

    // Default geometry widths
    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 11;

    // Input stream: restart flag in bit 0 of a one-byte tdata
    localparam int S_TDATA_W = 8;

    // Front-to-back item queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_RADIUS_X = 2'd2;
    localparam logic [1:0] REG_RADIUS_Y = 2'd3;

    // Walk phase
    typedef enum logic [1:0] {
        PH_R1   = 2'd0,
        PH_R2   = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_CHECK,
        ST_R2A,
        ST_R2B,
        ST_R2C,
        ST_R2D,
        ST_R2E,
        ST_EMIT,
        ST_STEP
    } t_eng_state;

    // Head of the item queue as seen by the back end
    typedef struct packed {
        logic valid;
        logic restart;
    } t_qhead;

endpackage

>>> rtl/core/mer_queue.sv
// Front end: accepts input items and holds them in a short queue.
// Depends on mer_pkg (queue depth, head struct).
module mer_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic            i_restart,
    output mer_pkg::t_qhead o_head,
    input  logic            i_pop
);

    logic                        r_mem [mer_pkg::QUEUE_DEPTH];
    logic [mer_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [mer_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [mer_pkg::QPTR_W:0]    r_count;
    logic                        push;
    logic                        pop;

    // Handshake: ready while the queue has room
    always_comb begin
        o_s_tready     = (r_count != (mer_pkg::QPTR_W + 1)'(mer_pkg::QUEUE_DEPTH));
        push           = i_s_tvalid && o_s_tready;
        pop            = i_pop && (r_count != '0);
        o_head.valid   = (r_count != '0);
        o_head.restart = r_mem[r_rd_ptr];
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_restart;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/core/mer_engine.sv
// Back end: walk sequencer, shared multiplier and output register.
// Depends on mer_pkg (states, phases, queue head struct).
module mer_engine #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS,
    parameter int TDATA_W     = ((4 * (COORD_BITS + 2) + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mer_pkg::t_qhead          i_head,
    output logic                     o_pop,
    input  logic [COORD_BITS-1:0]    i_center_x,
    input  logic [COORD_BITS-1:0]    i_center_y,
    input  logic [RADIUS_BITS-1:0]   i_radius_y,
    input  logic [2*RADIUS_BITS-1:0] i_rx2,
    input  logic [2*RADIUS_BITS-1:0] i_ry2,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [TDATA_W-1:0]       o_m_tdata,
    output logic                     o_m_tuser,
    output logic                     o_m_tlast
);

    localparam int OW  = COORD_BITS + 2;               // output coordinate
    localparam int YW  = RADIUS_BITS + 2;              // signed y offset
    localparam int SW  = 3 * RADIUS_BITS + 3;          // signed slope
    localparam int MA  = (2 * RADIUS_BITS > COORD_BITS + 1) ?
                         2 * RADIUS_BITS : COORD_BITS + 1;
    localparam int MB  = (COORD_BITS + 1 > YW) ? 2 * (COORD_BITS + 1) : 2 * YW;
    localparam int PW  = MA + MB;                      // product
    localparam int DW  = 2 * RADIUS_BITS + MB + 4;     // signed decision, scaled by 4
    localparam int EW  = OW + YW;                      // y coordinate sum

    // Registers
    mer_pkg::t_eng_state      r_state, n_state;
    mer_pkg::t_phase          r_phase, n_phase;
    logic                     r_br, n_br;
    logic [COORD_BITS-1:0]    r_x, n_x;
    logic signed [YW-1:0]     r_y, n_y;
    logic signed [SW-1:0]     r_sx, n_sx;
    logic signed [SW-1:0]     r_sy, n_sy;
    logic signed [DW-1:0]     r_dec, n_dec;
    logic signed [DW-1:0]     r_acc, n_acc;
    logic [MB-1:0]            r_tmp, n_tmp;
    logic [PW-1:0]            r_prod;
    logic                     r_m_tvalid, n_m_tvalid;
    logic [TDATA_W-1:0]       r_m_tdata, n_m_tdata;
    logic                     r_m_tuser, n_m_tuser;
    logic                     r_m_tlast, n_m_tlast;

    // Datapath helpers
    logic [MA-1:0]            mul_a;
    logic [MB-1:0]            mul_b;
    logic [COORD_BITS:0]      tx;
    logic signed [YW-1:0]     ty;
    logic [YW-1:0]            ty_abs;
    logic [SW:0]              slope_diff;
    logic                     out_free;
    logic [OW-1:0]            x_plus, x_minus, y_plus, y_minus;
    logic [EW-1:0]            y_sum, y_dif;
    logic signed [SW-1:0]     sel_a, sel_b, sel_c;
    logic signed [DW-1:0]     step_sum;

    // Coordinates of the current offset
    always_comb begin
        x_plus  = OW'(i_center_x) + OW'(r_x);
        x_minus = OW'(i_center_x) - OW'(r_x);
        y_sum   = EW'(i_center_y) + EW'(r_y);
        y_dif   = EW'(i_center_y) - EW'(r_y);
        y_plus  = y_sum[OW-1:0];
        y_minus = y_dif[OW-1:0];
    end

    // Region-two seed operands, region test and output-free check
    always_comb begin
        tx         = {r_x, 1'b1};
        ty         = r_y - YW'(1);
        ty_abs     = ty[YW-1] ? YW'(-ty) : YW'(ty);
        slope_diff = {r_sx[SW-1], r_sx} - {r_sy[SW-1], r_sy};
        out_free   = !r_m_tvalid || i_m_tready;
    end

    // Decision update terms: picked by phase and branch taken in the step
    always_comb begin
        sel_a = r_sx;
        sel_b = r_sy;
        sel_c = SW'(i_ry2);
        if (r_phase == mer_pkg::PH_R1) begin
            if (r_br) begin
                sel_b = '0;
            end
        end else begin
            sel_c = SW'(i_rx2);
            if (r_br) begin
                sel_a = '0;
            end
        end
        step_sum = DW'(sel_a) - DW'(sel_b) + DW'(sel_c);
    end

    // Sequencer: next state, datapath updates and multiplier operands
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_br       = r_br;
        n_x        = r_x;
        n_y        = r_y;
        n_sx       = r_sx;
        n_sy       = r_sy;
        n_dec      = r_dec;
        n_acc      = r_acc;
        n_tmp      = r_tmp;
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        n_m_tdata  = r_m_tdata;
        n_m_tuser  = r_m_tuser;
        n_m_tlast  = r_m_tlast;
        mul_a      = '0;
        mul_b      = '0;
        o_pop      = 1'b0;

        case (r_state)
            mer_pkg::ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    if (i_head.restart) begin
                        mul_a   = MA'(i_rx2);
                        mul_b   = MB'(i_radius_y);
                        n_state = mer_pkg::ST_INIT;
                    end else begin
                        n_state = mer_pkg::ST_CHECK;
                    end
                end
            end
            // New ellipse at the top point; r_prod = rx^2 * ry
            mer_pkg::ST_INIT: begin
                n_x     = '0;
                n_y     = YW'(i_radius_y);
                n_sx    = '0;
                n_sy    = SW'({r_prod, 1'b0});
                n_dec   = (DW'(i_ry2) << 2) - (DW'(r_prod) << 2) + DW'(i_rx2);
                n_phase = mer_pkg::PH_R1;
                n_state = mer_pkg::ST_CHECK;
            end
            mer_pkg::ST_CHECK: begin
                n_state = mer_pkg::ST_EMIT;
                case (r_phase)
                    mer_pkg::PH_R1: begin
                        if (!slope_diff[SW]) begin
                            mul_a   = MA'(tx);
                            mul_b   = MB'(tx);
                            n_state = mer_pkg::ST_R2A;
                        end
                    end
                    mer_pkg::PH_R2: begin
                        if (r_y[YW-1]) begin
                            n_phase = mer_pkg::PH_DONE;
                        end
                    end
                    default: begin
                        n_phase = mer_pkg::PH_DONE;
                    end
                endcase
            end
            // Region-two seed: ry^2*tx^2 + 4*rx^2*ty^2 - 4*rx^2*ry^2
            mer_pkg::ST_R2A: begin
                n_tmp   = r_prod[MB-1:0];
                mul_a   = MA'(ty_abs);
                mul_b   = MB'(ty_abs);
                n_state = mer_pkg::ST_R2B;
            end
            mer_pkg::ST_R2B: begin
                n_tmp   = r_prod[MB-1:0];
                mul_a   = MA'(i_ry2);
                mul_b   = r_tmp;
                n_state = mer_pkg::ST_R2C;
            end
            mer_pkg::ST_R2C: begin
                n_acc   = DW'(r_prod);
                mul_a   = MA'(i_rx2);
                mul_b   = r_tmp;
                n_state = mer_pkg::ST_R2D;
            end
            mer_pkg::ST_R2D: begin
                n_acc   = r_acc + (DW'(r_prod) << 2);
                mul_a   = MA'(i_rx2);
                mul_b   = MB'(i_ry2);
                n_state = mer_pkg::ST_R2E;
            end
            mer_pkg::ST_R2E: begin
                n_dec   = r_acc - (DW'(r_prod) << 2);
                n_phase = mer_pkg::PH_R2;
                n_state = mer_pkg::ST_CHECK;
            end
            // Emit the four points and move the offsets and slopes; a finished walk emits an empty item
            mer_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_m_tvalid = 1'b1;
                    if (r_phase == mer_pkg::PH_R1) begin
                        n_x  = r_x + 1'b1;
                        n_sx = r_sx + SW'({i_ry2, 1'b0});
                        n_br = r_dec[DW-1];
                        if (!r_dec[DW-1]) begin
                            n_y  = r_y - YW'(1);
                            n_sy = r_sy - SW'({i_rx2, 1'b0});
                        end
                        n_state = mer_pkg::ST_STEP;
                    end else if (r_phase == mer_pkg::PH_R2) begin
                        n_y  = r_y - YW'(1);
                        n_sy = r_sy - SW'({i_rx2, 1'b0});
                        n_br = !r_dec[DW-1] && (r_dec != '0);
                        if (r_dec[DW-1] || (r_dec == '0)) begin
                            n_x  = r_x + 1'b1;
                            n_sx = r_sx + SW'({i_ry2, 1'b0});
                        end
                        n_state = mer_pkg::ST_STEP;
                    end else begin
                        n_state = mer_pkg::ST_IDLE;
                    end
                    if (r_phase == mer_pkg::PH_R1 || r_phase == mer_pkg::PH_R2) begin
                        n_m_tdata = TDATA_W'({y_minus, y_plus, x_minus, x_plus});
                        n_m_tuser = 1'b1;
                        n_m_tlast = n_y[YW-1];
                    end else begin
                        n_m_tdata = '0;
                        n_m_tuser = 1'b0;
                        n_m_tlast = 1'b0;
                    end
                end
            end
            // Decision update from the new slopes
            mer_pkg::ST_STEP: begin
                n_dec   = r_dec + (step_sum <<< 2);
                n_state = mer_pkg::ST_IDLE;
            end
            default: begin
                n_state = mer_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mer_pkg::ST_IDLE;
            r_phase    <= mer_pkg::PH_DONE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    // Walk registers, shared multiplier and output payload
    always_ff @(posedge i_clk) begin
        r_br      <= n_br;
        r_x       <= n_x;
        r_y       <= n_y;
        r_sx      <= n_sx;
        r_sy      <= n_sy;
        r_dec     <= n_dec;
        r_acc     <= n_acc;
        r_tmp     <= n_tmp;
        r_prod    <= PW'(mul_a) * PW'(mul_b);
        r_m_tdata <= n_m_tdata;
        r_m_tuser <= n_m_tuser;
        r_m_tlast <= n_m_tlast;
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;
    assign o_m_tlast  = r_m_tlast;

endmodule

>>> rtl/core/midpoint_ellipse_rasterizer_unit.sv
// Midpoint ellipse rasterizer top level: configuration registers, radius squares,
// front queue (mer_queue) and walk engine (mer_engine). Depends on mer_pkg.
//
//  channel   direction  signals                        contents (low bit first)
//  s_axis    in         tvalid tready tdata[7:0]       restart
//  m_axis    out        tvalid tready tdata tuser tlast x_plus x_minus y_plus y_minus
//                                                      / points_valid / last_step
//  cfg       in         i_cfg_we i_cfg_addr i_cfg_wdata center_x center_y radius_x radius_y
//
//  An ordinary step runs through the engine states dequeue, region test, emit and decision update.
//  A restart adds an init state (one product on the shared multiplier); the switch to region two
//  adds the seed states, five products in sequence on that multiplier.
//  The queue keeps accepting items, while it has room, as the engine waits on a stalled output register.
//  Reset is synchronous, active low, and needs no clearing pass; the walk starts out finished.
module midpoint_ellipse_rasterizer_unit #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS,
    parameter int TDATA_W     = ((4 * (COORD_BITS + 2) + 7) / 8) * 8,
    parameter int CFG_W       = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // restart
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mer_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // x_plus, x_minus, y_plus, y_minus
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [TDATA_W-1:0]            m_axis_tdata,
    // points_valid
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_addr,
    input  logic [CFG_W-1:0]              i_cfg_wdata
);

    logic [COORD_BITS-1:0]    r_center_x;
    logic [COORD_BITS-1:0]    r_center_y;
    logic [RADIUS_BITS-1:0]   r_radius_x;
    logic [RADIUS_BITS-1:0]   r_radius_y;
    logic [2*RADIUS_BITS-1:0] r_rx2;
    logic [2*RADIUS_BITS-1:0] r_ry2;
    mer_pkg::t_qhead          head;
    logic                     pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_radius_x <= '0;
            r_radius_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mer_pkg::REG_CENTER_X: r_center_x <= i_cfg_wdata[COORD_BITS-1:0];
                mer_pkg::REG_CENTER_Y: r_center_y <= i_cfg_wdata[COORD_BITS-1:0];
                mer_pkg::REG_RADIUS_X: r_radius_x <= i_cfg_wdata[RADIUS_BITS-1:0];
                mer_pkg::REG_RADIUS_Y: r_radius_y <= i_cfg_wdata[RADIUS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Radius squares, registered from the radius registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx2 <= '0;
            r_ry2 <= '0;
        end else begin
            r_rx2 <= (2 * RADIUS_BITS)'(r_radius_x) * (2 * RADIUS_BITS)'(r_radius_x);
            r_ry2 <= (2 * RADIUS_BITS)'(r_radius_y) * (2 * RADIUS_BITS)'(r_radius_y);
        end
    end

    mer_queue u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_restart  (s_axis_tdata[0]),
        .o_head     (head),
        .i_pop      (pop)
    );

    mer_engine #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .TDATA_W     (TDATA_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_radius_y (r_radius_y),
        .i_rx2      (r_rx2),
        .i_ry2      (r_ry2),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser),
        .o_m_tlast  (m_axis_tlast)
    );

    // A finished walk reports all-zero coordinates and no last flag
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0 && !m_axis_tlast))
        else $error("non-plotted item carries data");

    // The last step is always a plotted step
    a_last_plotted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("last_step without points_valid");

    // The queue only fills up on an accepted item
    a_full_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid))
        else $error("input ready dropped without an accepted item");

endmodule
